// ===== hdl/lidar_polar_to_cartesian_defines.svh =====
// ---------------------------------------------------------------------------
// lidar_polar_to_cartesian_defines.svh
// Assertion macros for the lidar projection block.
// ---------------------------------------------------------------------------
`ifndef LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is asserted
`define LP2C_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lp2c check failed");
// clocked check, active during reset too
`define LP2C_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("lp2c check failed");
`else
`define LP2C_ASSERT(lbl, clk, rstn, prop)
`define LP2C_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/lp2c_pkg.sv =====
// ---------------------------------------------------------------------------
// lp2c_pkg
// Shared constants, types and tables of the lidar projection block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lp2c_pkg;

    localparam int MAX_SAMPLES   = 4096;
    localparam int CORDIC_STAGES = 20;
    // at most 24 rotations are used
    localparam int NSTAGES       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    localparam int RW  = 20;   // range width
    localparam int IW  = 12;   // index width
    localparam int AW  = 24;   // register angle / coefficient width
    localparam int OW  = 21;   // output coordinate width
    localparam int CW  = 34;   // CORDIC datapath width
    localparam int ANW = 40;   // wide angle width (elevation)

    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;
    localparam logic [29:0] CORDIC_GAIN  = 30'd652032874;
    localparam int          OUT_LIMIT    = 1048575;

    typedef enum logic [2:0] {
        REG_RANGE_LOW    = 3'd0,
        REG_RANGE_HIGH   = 3'd1,
        REG_START_ANGLE  = 3'd2,
        REG_ANGLE_STEP   = 3'd3,
        REG_COEFF_SQUARE = 3'd4,
        REG_COEFF_LINEAR = 3'd5,
        REG_COEFF_OFFSET = 3'd6
    } t_reg_addr;

    // state of both rotators plus the range riding along
    typedef struct packed {
        logic signed [CW-1:0] xh;
        logic signed [CW-1:0] yh;
        logic signed [CW-1:0] zh;
        logic signed [CW-1:0] xv;
        logic signed [CW-1:0] yv;
        logic signed [CW-1:0] zv;
        logic [1:0]           qh;
        logic [1:0]           qv;
        logic [RW-1:0]        r;
    } t_cell_data;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/lp2c_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// lp2c_cordic_cell
// One CORDIC rotation step for the azimuth and elevation rotators.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lp2c_cordic_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_stage,
    input  logic                  i_valid,
    input  lp2c_pkg::t_cell_data  i_data,
    input  logic                  i_down_en,
    output logic                  o_up_en,
    output logic                  o_valid,
    output lp2c_pkg::t_cell_data  o_data
);

    logic                          r_valid;
    lp2c_pkg::t_cell_data          r_data;
    lp2c_pkg::t_cell_data          n_data;
    logic signed [lp2c_pkg::CW-1:0] atan;

    assign atan = $signed({{(lp2c_pkg::CW-32){1'b0}}, lp2c_pkg::atan_turn(i_stage)});

    // rotate toward zero residual angle
    always_comb begin
        n_data = i_data;
        if (!i_data.zh[lp2c_pkg::CW-1]) begin
            n_data.xh = i_data.xh - (i_data.yh >>> i_stage);
            n_data.yh = i_data.yh + (i_data.xh >>> i_stage);
            n_data.zh = i_data.zh - atan;
        end else begin
            n_data.xh = i_data.xh + (i_data.yh >>> i_stage);
            n_data.yh = i_data.yh - (i_data.xh >>> i_stage);
            n_data.zh = i_data.zh + atan;
        end
        if (!i_data.zv[lp2c_pkg::CW-1]) begin
            n_data.xv = i_data.xv - (i_data.yv >>> i_stage);
            n_data.yv = i_data.yv + (i_data.xv >>> i_stage);
            n_data.zv = i_data.zv - atan;
        end else begin
            n_data.xv = i_data.xv + (i_data.yv >>> i_stage);
            n_data.yv = i_data.yv - (i_data.xv >>> i_stage);
            n_data.zv = i_data.zv + atan;
        end
    end

    // cell advances when empty or when the next cell moves
    assign o_up_en = !r_valid || i_down_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_en) begin
            r_valid <= i_valid;
        end
        if (o_up_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/lp2c_cordic.sv =====
// ---------------------------------------------------------------------------
// lp2c_cordic
// Row of CORDIC cells, one rotation per cell, with a per-cell stall chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lp2c_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lp2c_pkg::t_cell_data  i_data,
    input  logic                  i_down_en,
    output logic                  o_up_en,
    output logic                  o_valid,
    output lp2c_pkg::t_cell_data  o_data
);

    localparam int N = lp2c_pkg::NSTAGES;

    logic                 valid [N+1];
    lp2c_pkg::t_cell_data data  [N+1];
    logic                 en    [N+1];

    assign valid[0] = i_valid;
    assign data[0]  = i_data;
    assign en[N]    = i_down_en;

    // cell k takes beat from cell k-1
    for (genvar k = 0; k < N; k++) begin : g_cell
        lp2c_cordic_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_stage   (5'(k)),
            .i_valid   (valid[k]),
            .i_data    (data[k]),
            .i_down_en (en[k+1]),
            .o_up_en   (en[k]),
            .o_valid   (valid[k+1]),
            .o_data    (data[k+1])
        );
    end

    assign o_up_en = en[0];
    assign o_valid = valid[N];
    assign o_data  = data[N];

endmodule

// ===== hdl/lidar_polar_to_cartesian.sv =====
// ---------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Projects lidar range samples to cartesian points in millimetres.
// ---------------------------------------------------------------------------
// Input beat on s_axis: range and sample index. Output beat on m_axis: x, y, z.
// Samples outside the configured range window (or index past the scan) make
// no output beat. Registers are written over the APB port; the user must
// write them only while idle, the block does not enforce it. Throughput:
// one beat per cycle, sustained while the receiver does not stall; every
// stage and every CORDIC cell holds a beat and moves it on when its
// successor is free. A beat passes 8 front stages (angle, elevation
// polynomial, phase), the CORDIC row, 4 back stages, output register.
// When the receiver stalls, beats pile up stage by stage; s_axis_tready
// drops only once the whole pipe is full.
// Reset clears all stage valids and sets the registers to their defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lidar_polar_to_cartesian_defines.svh"

module lidar_polar_to_cartesian (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // range_mm[19:0], sample_index[31:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // x_mm[20:0], y_mm[41:21], z_mm[62:42]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW = lp2c_pkg::RW;
    localparam int AW = lp2c_pkg::AW;
    localparam int CW = lp2c_pkg::CW;
    localparam int OW = lp2c_pkg::OW;
    localparam int ANW = lp2c_pkg::ANW;

    // ---------------- configuration registers ----------------
    logic [RW-1:0]        r_range_low, r_range_high;
    logic signed [AW-1:0] r_start, r_step, r_csq, r_clin, r_coff;
    logic                 wr_en;
    lp2c_pkg::t_reg_addr  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = lp2c_pkg::t_reg_addr'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= 20'hFFFFF;
            r_start      <= '0;
            r_step       <= '0;
            r_csq        <= '0;
            r_clin       <= '0;
            r_coff       <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                lp2c_pkg::REG_RANGE_LOW:    r_range_low  <= pwdata[RW-1:0];
                lp2c_pkg::REG_RANGE_HIGH:   r_range_high <= pwdata[RW-1:0];
                lp2c_pkg::REG_START_ANGLE:  r_start      <= pwdata[AW-1:0];
                lp2c_pkg::REG_ANGLE_STEP:   r_step       <= pwdata[AW-1:0];
                lp2c_pkg::REG_COEFF_SQUARE: r_csq        <= pwdata[AW-1:0];
                lp2c_pkg::REG_COEFF_LINEAR: r_clin       <= pwdata[AW-1:0];
                lp2c_pkg::REG_COEFF_OFFSET: r_coff       <= pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_sel)
            lp2c_pkg::REG_RANGE_LOW:    prdata = {12'd0, r_range_low};
            lp2c_pkg::REG_RANGE_HIGH:   prdata = {12'd0, r_range_high};
            lp2c_pkg::REG_START_ANGLE:  prdata = {8'd0, r_start};
            lp2c_pkg::REG_ANGLE_STEP:   prdata = {8'd0, r_step};
            lp2c_pkg::REG_COEFF_SQUARE: prdata = {8'd0, r_csq};
            lp2c_pkg::REG_COEFF_LINEAR: prdata = {8'd0, r_clin};
            lp2c_pkg::REG_COEFF_OFFSET: prdata = {8'd0, r_coff};
            default:                    prdata = '0;
        endcase
    end

    // ---------------- stall chain ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic r_v9, r_v10, r_v11, r_v12, r_vo;
    logic en1, en2, en3, en4, en5, en6, en7, en8;
    logic en9, en10, en11, en12, eno;
    logic cord_up_en, cord_valid;
    lp2c_pkg::t_cell_data cord_in, cord_out;

    assign eno  = !r_vo  || m_axis_tready;
    assign en12 = !r_v12 || eno;
    assign en11 = !r_v11 || en12;
    assign en10 = !r_v10 || en11;
    assign en9  = !r_v9  || en10;
    assign en8  = !r_v8  || cord_up_en;
    assign en7  = !r_v7  || en8;
    assign en6  = !r_v6  || en7;
    assign en5  = !r_v5  || en6;
    assign en4  = !r_v4  || en5;
    assign en3  = !r_v3  || en4;
    assign en2  = !r_v2  || en3;
    assign en1  = !r_v1  || en2;
    assign s_axis_tready = en1;

    // ---------------- S1: window test, step * index ----------------
    logic [RW-1:0]  in_r;
    logic [11:0]    in_idx;
    logic           keep;
    logic [RW-1:0]  r_r1;
    logic signed [36:0] r_prod1;

    assign in_r   = s_axis_tdata[19:0];
    assign in_idx = s_axis_tdata[31:20];
    assign keep   = s_axis_tvalid && (in_r >= r_range_low) && (in_r < r_range_high)
                    && (17'(in_idx) < 17'(lp2c_pkg::MAX_SAMPLES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en1) r_v1 <= keep;
        if (en1) begin
            r_r1    <= in_r;
            r_prod1 <= r_step * $signed({1'b0, in_idx});
        end
    end

    // ---------------- S2: azimuth with saturation ----------------
    logic signed [37:0] hsum;
    logic signed [AW-1:0] hsat;
    logic [RW-1:0]  r_r2;
    logic signed [AW-1:0] r_h2;

    assign hsum = 38'(r_start) + 38'(r_prod1);
    always_comb begin
        if (hsum > 38'sd8388607)       hsat = 24'sh7FFFFF;
        else if (hsum < -38'sd8388608) hsat = 24'sh800000;
        else                           hsat = hsum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en2) r_v2 <= r_v1;
        if (en2) begin
            r_r2 <= r_r1;
            r_h2 <= hsat;
        end
    end

    // ---------------- S3: h^2 and linear term ----------------
    logic [RW-1:0] r_r3;
    logic signed [AW-1:0] r_h3;
    logic signed [47:0] r_hh3, r_lin3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_v2;
        if (en3) begin
            r_r3   <= r_r2;
            r_h3   <= r_h2;
            r_hh3  <= r_h2 * r_h2;
            r_lin3 <= r_clin * r_h2;
        end
    end

    // ---------------- S4: rounded h^2 times square coefficient ----------------
    logic signed [47:0] hh_rnd;
    logic signed [28:0] hsq;
    logic [RW-1:0] r_r4;
    logic signed [AW-1:0] r_h4;
    logic signed [47:0] r_lin4;
    logic signed [52:0] r_sq4;

    assign hh_rnd = r_hh3 + 48'sd524288;
    assign hsq    = $signed({1'b0, hh_rnd[47:20]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en4) r_v4 <= r_v3;
        if (en4) begin
            r_r4   <= r_r3;
            r_h4   <= r_h3;
            r_lin4 <= r_lin3;
            r_sq4  <= r_csq * hsq;
        end
    end

    // ---------------- S5: elevation sum, round to 2^-20 rad ----------------
    logic signed [55:0] acc;
    logic [RW-1:0] r_r5;
    logic signed [AW-1:0] r_h5;
    logic signed [ANW-1:0] r_ev5;

    assign acc = 56'(r_sq4) + 56'(r_lin4) + (56'(r_coff) <<< 20) + 56'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (en5) r_v5 <= r_v4;
        if (en5) begin
            r_r5  <= r_r4;
            r_h5  <= r_h4;
            r_ev5 <= acc[55:16];
        end
    end

    // ---------------- S6: phase partial products ----------------
    // angle = hi*2^20 + lo; phase = hi*K + round(lo*K / 2^20) mod 2^32
    logic signed [ANW-1:0] hw;
    logic signed [30:0]    kk;
    logic signed [50:0]    mhh_full, mvh_full;
    logic [RW-1:0] r_r6;
    logic [31:0]   r_mhh6, r_mvh6;
    logic [49:0]   r_mhl6, r_mvl6;

    assign hw       = ANW'(r_h5);
    assign kk       = $signed({1'b0, lp2c_pkg::TURN_PER_RAD});
    assign mhh_full = $signed(hw[ANW-1:20]) * kk;
    assign mvh_full = $signed(r_ev5[ANW-1:20]) * kk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (en6) r_v6 <= r_v5;
        if (en6) begin
            r_r6   <= r_r5;
            r_mhh6 <= mhh_full[31:0];
            r_mvh6 <= mvh_full[31:0];
            r_mhl6 <= hw[19:0] * lp2c_pkg::TURN_PER_RAD;
            r_mvl6 <= r_ev5[19:0] * lp2c_pkg::TURN_PER_RAD;
        end
    end

    // ---------------- S7: phases in 2^-32 turn ----------------
    logic [50:0] lh, lv;
    logic [RW-1:0] r_r7;
    logic [31:0] r_ph7, r_pv7;

    assign lh = 51'(r_mhl6) + 51'd524288;
    assign lv = 51'(r_mvl6) + 51'd524288;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (en7) r_v7 <= r_v6;
        if (en7) begin
            r_r7  <= r_r6;
            r_ph7 <= r_mhh6 + {1'b0, lh[50:20]};
            r_pv7 <= r_mvh6 + {1'b0, lv[50:20]};
        end
    end

    // ---------------- S8: quadrant split, rotator start ----------------
    logic [31:0] qh_sum, qv_sum, dh, dv;
    lp2c_pkg::t_cell_data n_cord;
    lp2c_pkg::t_cell_data r_cord8;

    assign qh_sum = r_ph7 + 32'h2000_0000;
    assign qv_sum = r_pv7 + 32'h2000_0000;
    assign dh     = r_ph7 - {qh_sum[31:30], 30'd0};
    assign dv     = r_pv7 - {qv_sum[31:30], 30'd0};

    always_comb begin
        n_cord.xh = $signed({{(CW-30){1'b0}}, lp2c_pkg::CORDIC_GAIN});
        n_cord.yh = '0;
        n_cord.zh = CW'($signed(dh));
        n_cord.xv = $signed({{(CW-30){1'b0}}, lp2c_pkg::CORDIC_GAIN});
        n_cord.yv = '0;
        n_cord.zv = CW'($signed(dv));
        n_cord.qh = qh_sum[31:30];
        n_cord.qv = qv_sum[31:30];
        n_cord.r  = r_r7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v8 <= 1'b0;
        else if (en8) r_v8 <= r_v7;
        if (en8) begin
            r_cord8 <= n_cord;
        end
    end

    assign cord_in = r_cord8;

    lp2c_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v8),
        .i_data    (cord_in),
        .i_down_en (en9),
        .o_up_en   (cord_up_en),
        .o_valid   (cord_valid),
        .o_data    (cord_out)
    );

    // ---------------- S9: quadrant fold-back ----------------
    logic signed [CW-1:0] ch, sh, cv, sv;
    logic [RW-1:0] r_r9;
    logic signed [31:0] r_ch9, r_sh9, r_cv9, r_sv9;

    always_comb begin
        case (cord_out.qh)
            2'd0:    begin ch =  cord_out.xh; sh =  cord_out.yh; end
            2'd1:    begin ch = -cord_out.yh; sh =  cord_out.xh; end
            2'd2:    begin ch = -cord_out.xh; sh = -cord_out.yh; end
            default: begin ch =  cord_out.yh; sh = -cord_out.xh; end
        endcase
        case (cord_out.qv)
            2'd0:    begin cv =  cord_out.xv; sv =  cord_out.yv; end
            2'd1:    begin cv = -cord_out.yv; sv =  cord_out.xv; end
            2'd2:    begin cv = -cord_out.xv; sv = -cord_out.yv; end
            default: begin cv =  cord_out.yv; sv = -cord_out.xv; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v9 <= 1'b0;
        else if (en9) r_v9 <= cord_valid;
        if (en9) begin
            r_r9  <= cord_out.r;
            r_ch9 <= ch[31:0];
            r_sh9 <= sh[31:0];
            r_cv9 <= cv[31:0];
            r_sv9 <= sv[31:0];
        end
    end

    // ---------------- S10: direction products ----------------
    logic [RW-1:0] r_r10;
    logic signed [31:0] r_sv10;
    logic signed [63:0] r_pcc10, r_psc10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v10 <= 1'b0;
        else if (en10) r_v10 <= r_v9;
        if (en10) begin
            r_r10   <= r_r9;
            r_sv10  <= r_sv9;
            r_pcc10 <= r_ch9 * r_cv9;
            r_psc10 <= r_sh9 * r_cv9;
        end
    end

    // ---------------- S11: round direction to 2^-30 ----------------
    logic signed [63:0] pcc_rnd, psc_rnd;
    logic [RW-1:0] r_r11;
    logic signed [31:0] r_sv11;
    logic signed [33:0] r_mx11, r_my11;

    assign pcc_rnd = r_pcc10 + 64'sd536870912;
    assign psc_rnd = r_psc10 + 64'sd536870912;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v11 <= 1'b0;
        else if (en11) r_v11 <= r_v10;
        if (en11) begin
            r_r11  <= r_r10;
            r_sv11 <= r_sv10;
            r_mx11 <= pcc_rnd[63:30];
            r_my11 <= psc_rnd[63:30];
        end
    end

    // ---------------- S12: scale by range ----------------
    logic signed [RW:0] rs;
    logic signed [54:0] r_px12, r_py12, r_pz12;

    assign rs = $signed({1'b0, r_r11});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v12 <= 1'b0;
        else if (en12) r_v12 <= r_v11;
        if (en12) begin
            r_px12 <= r_mx11 * rs;
            r_py12 <= r_my11 * rs;
            r_pz12 <= 55'(r_sv11) * 55'(rs);
        end
    end

    // ---------------- output register: round to mm, saturate ----------------
    function automatic logic signed [OW-1:0] rnd_sat(input logic signed [54:0] p);
        logic signed [54:0] t;
        logic signed [24:0] q;
        logic signed [OW-1:0] o;
        t = p + 55'sd536870912;
        q = t[54:30];
        if (q > 25'(lp2c_pkg::OUT_LIMIT))       o = OW'(lp2c_pkg::OUT_LIMIT);
        else if (q < -25'(lp2c_pkg::OUT_LIMIT)) o = -OW'(lp2c_pkg::OUT_LIMIT);
        else                                    o = q[OW-1:0];
        return o;
    endfunction

    logic signed [OW-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vo <= 1'b0;
        else if (eno) r_vo <= r_v12;
        if (eno) begin
            r_x  <= rnd_sat(r_px12);
            r_y  <= rnd_sat(r_py12);
            r_z  <= rnd_sat(r_pz12);
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {1'b0, r_z, r_y, r_x};

    // ---------------- checks ----------------
    logic out_blocked, low_wr;

    assign out_blocked = m_axis_tvalid && !m_axis_tready;
    assign low_wr      = wr_en && (reg_sel == lp2c_pkg::REG_RANGE_LOW);

    `LP2C_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready |-> out_blocked)
    `LP2C_ASSERT(a_x_saturated, i_clk, i_rst_n, m_axis_tvalid |-> (r_x != 21'h100000))
    `LP2C_ASSERT(a_low_written, i_clk, i_rst_n, low_wr |=> (r_range_low == $past(pwdata[19:0])))

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar polar-to-cartesian projection block.
// Directed tables, then random samples, are pushed on s_axis; each output
// point is checked against a typed-in value or a bit-accurate fixed-point
// predictor of the projection (angle, elevation polynomial, CORDIC sine/cosine, products).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 80;

    typedef struct packed {
        logic signed [20:0] z;
        logic signed [20:0] y;
        logic signed [20:0] x;
    } t_point;

    typedef struct {
        logic [19:0] rng;
        logic [11:0] idx;
        bit          fixed;   // expected point typed in below
        t_point      pt;
    } t_row;

    logic        i_clk, i_rst_n;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    // shadow copy of the register file
    logic [31:0] cfg [7];

    t_point point_queue[$];
    int     errors, points_seen, samples_sent, idle_cycles;
    bit     no_idle;

    lidar_polar_to_cartesian dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint asr_f(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_f(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint sat_f(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sext_f(logic [31:0] v, int w);
        longint t;
        t = longint'(v) & ((longint'(1) << w) - 1);
        if (t[w-1]) t = t - (longint'(1) << w);
        return t;
    endfunction

    // cos/sin of an angle in 2^-20 rad, results in 2^-30
    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        logic [63:0] prod;
        logic [31:0] ph, d;
        logic [1:0]  q;
        longint x, y, z, dx, dy;
        prod = 64'(ang) * 64'(lp2c_pkg::TURN_PER_RAD);
        ph   = 32'((prod + 64'(1 << 19)) >> 20);
        q    = 2'((ph + 32'h2000_0000) >> 30);
        d    = ph - {q, 30'd0};
        z    = longint'(signed'(d));
        x    = longint'(lp2c_pkg::CORDIC_GAIN);
        y    = 0;
        for (int i = 0; i < lp2c_pkg::NSTAGES; i++) begin
            dx = asr_f(y, i);
            dy = asr_f(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(lp2c_pkg::atan_turn(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(lp2c_pkg::atan_turn(5'(i)));
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // returns 1 and the point when the sample projects to a point
    task automatic project_sample(input logic [19:0] rng, input logic [11:0] idx,
                                  output bit hit, output t_point pt);
        longint h, hsq, acc, v, ch, sh, cv, sv, m, r;
        hit = 0;
        pt  = '0;
        if (rng < cfg[lp2c_pkg::REG_RANGE_LOW][19:0]
            || rng >= cfg[lp2c_pkg::REG_RANGE_HIGH][19:0]
            || idx >= lp2c_pkg::MAX_SAMPLES) return;
        hit = 1;
        r   = longint'(rng);
        h   = sext_f(cfg[lp2c_pkg::REG_START_ANGLE], 24)
            + sext_f(cfg[lp2c_pkg::REG_ANGLE_STEP], 24) * longint'(idx);
        h   = sat_f(h, -(longint'(1) << 23), (longint'(1) << 23) - 1);
        hsq = round_f(h * h, 20);
        acc = sext_f(cfg[lp2c_pkg::REG_COEFF_SQUARE], 24) * hsq
            + sext_f(cfg[lp2c_pkg::REG_COEFF_LINEAR], 24) * h
            + sext_f(cfg[lp2c_pkg::REG_COEFF_OFFSET], 24) * (longint'(1) << 20);
        v   = round_f(acc, 16);
        cordic_sincos(h, ch, sh);
        cordic_sincos(v, cv, sv);
        m    = round_f(ch * cv, 30);
        pt.x = 21'(sat_f(round_f(m * r, 30), -lp2c_pkg::OUT_LIMIT, lp2c_pkg::OUT_LIMIT));
        m    = round_f(sh * cv, 30);
        pt.y = 21'(sat_f(round_f(m * r, 30), -lp2c_pkg::OUT_LIMIT, lp2c_pkg::OUT_LIMIT));
        pt.z = 21'(sat_f(round_f(sv * r, 30), -lp2c_pkg::OUT_LIMIT, lp2c_pkg::OUT_LIMIT));
    endtask

    // ---------------- drivers ----------------
    task automatic apb_write(input lp2c_pkg::t_reg_addr ra, input logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 5'(ra) << 2; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cfg[ra] = val;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic send_sample(input logic [19:0] rng, input logic [11:0] idx,
                               input bit fixed, input t_point fx);
        bit     hit;
        t_point pt;
        t_point want_pt;
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {idx, rng};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        project_sample(rng, idx, hit, pt);
        if (hit) begin
            want_pt     = fixed ? fx : pt;
            point_queue = {point_queue, want_pt};
        end
        samples_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait for all points, then let the pipe settle before a register write
    task automatic drain_pipe();
        while (point_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // random receiver stalls
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    end

    // output checker and watchdog
    always @(posedge i_clk) begin
        t_point got, want;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[62:0];
                points_seen++;
                if (point_queue.size() == 0) begin
                    $display("%0t: unexpected point x=%0d y=%0d z=%0d", $realtime,
                             got.x, got.y, got.z);
                    errors++;
                end else begin
                    want = point_queue.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: x exp %0d got %0d", $realtime, want.x, got.x);
                        errors++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: y exp %0d got %0d", $realtime, want.y, got.y);
                        errors++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t: z exp %0d got %0d", $realtime, want.z, got.z);
                        errors++;
                    end
                end
            end
        end
    end

    // range window and angle/coefficient set for one random phase
    task automatic random_geometry(input bit extreme);
        apb_write(lp2c_pkg::REG_RANGE_LOW,
                  $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 2000));
        apb_write(lp2c_pkg::REG_RANGE_HIGH,
                  $urandom_range(0, 3) == 0 ? 32'hFFFFF : $urandom_range(1000, 1048575));
        apb_write(lp2c_pkg::REG_START_ANGLE, $urandom() & 32'hFFFFFF);
        apb_write(lp2c_pkg::REG_ANGLE_STEP, extreme ? $urandom() & 32'hFFFFFF
                  : 32'(signed'($urandom_range(0, 8000)) - 4000));
        apb_write(lp2c_pkg::REG_COEFF_SQUARE, extreme ? $urandom() & 32'hFFFFFF
                  : 32'($urandom_range(0, 200)) - 100);
        apb_write(lp2c_pkg::REG_COEFF_LINEAR, extreme ? $urandom() & 32'hFFFFFF
                  : 32'($urandom_range(0, 20000)) - 10000);
        apb_write(lp2c_pkg::REG_COEFF_OFFSET, $urandom() & 32'hFFFFFF);
    endtask

    // ---------------- main sequence ----------------
    initial begin
        t_row   dir_rows [5];
        logic [19:0] win_rng [6];
        t_point zero_pt;
        logic [19:0] rlo, rhi, rr;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        samples_sent = 0; no_idle = 0;
        foreach (cfg[i]) cfg[i] = '0;
        cfg[lp2c_pkg::REG_RANGE_HIGH] = 32'hFFFFF;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table at reset defaults: angle zero, so x = r, y = z = 0
        zero_pt = '0;
        dir_rows[0] = '{20'd0, 12'd0, 1, zero_pt};
        dir_rows[1] = '{20'd1, 12'd0, 1, '{z: 21'sd0, y: 21'sd0, x: 21'sd1}};
        dir_rows[2] = '{20'd1000, 12'd4095, 1, '{z: 21'sd0, y: 21'sd0, x: 21'sd1000}};
        dir_rows[3] = '{20'hFFFFE, 12'd0, 0, zero_pt};   // largest in-window range
        dir_rows[4] = '{20'hFFFFF, 12'd7, 0, zero_pt};   // at exclusive bound: dropped
        foreach (dir_rows[i])
            send_sample(dir_rows[i].rng, dir_rows[i].idx, dir_rows[i].fixed, dir_rows[i].pt);
        drain_pipe();

        // range window and angle extremes, checked by the predictor
        apb_write(lp2c_pkg::REG_RANGE_LOW, 32'd100);
        apb_write(lp2c_pkg::REG_RANGE_HIGH, 32'd200);
        apb_write(lp2c_pkg::REG_START_ANGLE, 32'h7FFFFF);
        apb_write(lp2c_pkg::REG_ANGLE_STEP, 32'h7FFFFF);
        apb_write(lp2c_pkg::REG_COEFF_SQUARE, 32'h7FFFFF);
        apb_write(lp2c_pkg::REG_COEFF_LINEAR, 32'h800000);
        apb_write(lp2c_pkg::REG_COEFF_OFFSET, 32'h7FFFFF);
        win_rng = '{20'd99, 20'd100, 20'd150, 20'd199, 20'd200, 20'hFFFFF};
        foreach (win_rng[k]) send_sample(win_rng[k], 12'(k * 819), 0, zero_pt);
        drain_pipe();

        // negative saturation of the angle, large elevation wrap
        apb_write(lp2c_pkg::REG_RANGE_LOW, 32'd0);
        apb_write(lp2c_pkg::REG_RANGE_HIGH, 32'hFFFFF);
        apb_write(lp2c_pkg::REG_START_ANGLE, 32'h800000);
        apb_write(lp2c_pkg::REG_ANGLE_STEP, 32'h800000);
        apb_write(lp2c_pkg::REG_COEFF_SQUARE, 32'h800000);
        apb_write(lp2c_pkg::REG_COEFF_LINEAR, 32'h7FFFFF);
        apb_write(lp2c_pkg::REG_COEFF_OFFSET, 32'h800000);
        for (int k = 0; k < 6; k++)
            send_sample(20'hFFFFE - 20'(k), 12'(k * 800 + 1), 0, zero_pt);
        send_sample(20'h55555, 12'hAAA, 0, zero_pt);
        drain_pipe();

        // empty window: low >= high drops everything
        apb_write(lp2c_pkg::REG_RANGE_LOW, 32'd500);
        apb_write(lp2c_pkg::REG_RANGE_HIGH, 32'd500);
        for (int k = 0; k < 4; k++) send_sample(20'($urandom()), 12'($urandom()), 0, zero_pt);
        drain_pipe();

        // random phases, new register settings each time
        for (int ph = 0; ph < 8; ph++) begin
            random_geometry(ph % 3 == 2);
            rlo = cfg[lp2c_pkg::REG_RANGE_LOW][19:0];
            rhi = cfg[lp2c_pkg::REG_RANGE_HIGH][19:0];
            if (ph == 7) no_idle = 1;
            for (int k = 0; k < 115; k++) begin
                // mostly in-window ranges, some anywhere
                if ($urandom_range(0, 9) < 8 && rhi > rlo)
                    rr = 20'($urandom_range(rlo, rhi - 1));
                else
                    rr = 20'($urandom());
                send_sample(rr, 12'($urandom()), 0, zero_pt);
            end
            drain_pipe();
        end

        if (point_queue.size() != 0) begin
            $display("%0t: %0d points never arrived", $realtime, point_queue.size());
            errors += point_queue.size();
        end
        $display("Sent %0d samples over 12 register settings, %0d points checked.",
                 samples_sent, points_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== lidar_polar_to_cartesian.f =====
+incdir+hdl
hdl/lp2c_pkg.sv
hdl/lp2c_cordic_cell.sv
hdl/lp2c_cordic.sv
hdl/lidar_polar_to_cartesian.sv
verif/testbench.sv
